>>> hw/rtl/crmt_pkg.sv
// ----------------------------------------------------------------------------
// crmt_pkg
// Types and codes shared by the receive mailbox table front and back ends.
// ----------------------------------------------------------------------------
package crmt_pkg;

  localparam int unsigned IdW      = 29;
  localparam int unsigned LenW     = 4;
  localparam int unsigned DataW    = 64;
  localparam int unsigned SlotIdxW = 4;
  localparam int unsigned MaxLen   = 8;
  localparam int unsigned QDepth   = 2;

  typedef enum logic [1:0] {
    OP_ASSIGN = 2'd0,
    OP_FRAME  = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_RESP = 2'd2
  } state_e;

  typedef struct packed {
    op_e              op;
    logic             bus;
    logic [IdW-1:0]   id;
    logic             ext;
    logic             rtr;
    logic [LenW-1:0]  len;
    logic [DataW-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [SlotIdxW-1:0] slot_index;
    logic                channel;
    logic [LenW-1:0]     length;
    logic                remote;
    logic [DataW-1:0]    payload;
  } res_t;

  typedef struct packed {
    logic [IdW-1:0]   ident;
    logic             ext;
    logic             full;
    logic             bus;
    logic [LenW-1:0]  len;
    logic             rtr;
    logic [DataW-1:0] bytes;
  } ent_t;

endpackage

>>> hw/rtl/crmt_front.sv
// ----------------------------------------------------------------------------
// crmt_front
// Accepts requests, decodes the type, saturates the length, clears bytes
// beyond the length and holds the request in a two-entry queue.
// ----------------------------------------------------------------------------
module crmt_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic [1:0]                  req_type_i,
  input  logic                        bus_i,
  input  logic [crmt_pkg::IdW-1:0]    can_id_i,
  input  logic                        id_extended_i,
  input  logic                        remote_in_i,
  input  logic [crmt_pkg::LenW-1:0]   length_in_i,
  input  logic [crmt_pkg::DataW-1:0]  payload_in_i,
  output logic                        cmd_vld_o,
  output crmt_pkg::cmd_t              cmd_o,
  input  logic                        cmd_take_i
);
  import crmt_pkg::*;

  cmd_t            q_mem_q [QDepth];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push_ok;
  logic [LenW-1:0] len_sat;
  logic [DataW-1:0] data_msk;
  cmd_t            cmd_new;

  // length saturation and byte masking
  always_comb begin
    if (length_in_i > LenW'(MaxLen)) begin
      len_sat = LenW'(MaxLen);
    end else begin
      len_sat = length_in_i;
    end
    for (int b = 0; b < 8; b++) begin
      if (LenW'(b) < len_sat) begin
        data_msk[b*8 +: 8] = payload_in_i[b*8 +: 8];
      end else begin
        data_msk[b*8 +: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    cmd_new.op   = op_e'(req_type_i);
    cmd_new.bus  = bus_i;
    cmd_new.id   = can_id_i;
    cmd_new.ext  = id_extended_i;
    cmd_new.rtr  = remote_in_i;
    cmd_new.len  = len_sat;
    cmd_new.data = data_msk;
  end

  assign full_o    = (cnt_q == 2'(QDepth));
  assign push_ok   = push_i && !full_o;
  assign cmd_vld_o = (cnt_q != 2'd0);
  assign cmd_o     = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_ok;
    rd_ptr_d = rd_ptr_q ^ cmd_take_i;
    cnt_d    = cnt_q + 2'(push_ok) - 2'(cmd_take_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      q_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

>>> hw/rtl/crmt_back.sv
// ----------------------------------------------------------------------------
// crmt_back
// Executes requests against the slot memory: binds slots, scans for the
// first matching slot one entry per cycle and holds the result register.
// ----------------------------------------------------------------------------
module crmt_back #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_vld_i,
  input  crmt_pkg::cmd_t              cmd_i,
  output logic                        cmd_take_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output crmt_pkg::res_t              res_o
);
  import crmt_pkg::*;

  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  ent_t            mem_q [SLOTS];
  ent_t            rdata_q;
  state_e          state_q, state_d;
  cmd_t            cmd_q, cmd_d;
  res_t            res_q, res_d;
  res_t            out_q;
  logic            out_vld_q;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   scan_q, scan_d;
  logic            chk_q, chk_d;
  logic [IW-1:0]   chk_idx_q, chk_idx_d;
  logic            we, rd_en;
  logic [IW-1:0]   waddr, raddr;
  ent_t            wdata;
  logic            hit, scan_end, out_free, tab_full;

  function automatic logic [SlotIdxW-1:0] slot_idx(input logic [IW-1:0] i);
    logic [IW+SlotIdxW-1:0] w;
    w = {{SlotIdxW{1'b0}}, i};
    return w[SlotIdxW-1:0];
  endfunction

  assign hit = chk_q && (rdata_q.ident == cmd_q.id) && (rdata_q.ext == cmd_q.ext)
               && (rdata_q.full == (cmd_q.op == OP_READ));
  assign scan_end = (scan_q >= count_q);
  assign out_free = !out_vld_q || pop_i;
  assign tab_full = (count_q == CW'(SLOTS));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_vld_i) begin
          if (cmd_i.op == OP_FRAME || cmd_i.op == OP_READ) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (hit || scan_end) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    cmd_take_o = 1'b0;
    cmd_d      = cmd_q;
    res_d      = res_q;
    count_d    = count_q;
    scan_d     = scan_q;
    chk_d      = chk_q;
    chk_idx_d  = chk_idx_q;
    we         = 1'b0;
    waddr      = chk_idx_q;
    wdata      = rdata_q;
    rd_en      = 1'b0;
    raddr      = scan_q[IW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (cmd_vld_i) begin
          cmd_take_o   = 1'b1;
          cmd_d        = cmd_i;
          scan_d       = '0;
          chk_d        = 1'b0;
          res_d        = '0;
          res_d.status = ST_NONE;
          if (cmd_i.op == OP_ASSIGN) begin
            if (tab_full) begin
              res_d.status = ST_FULL;
            end else begin
              we               = 1'b1;
              waddr            = count_q[IW-1:0];
              wdata            = '0;
              wdata.ident      = cmd_i.id;
              wdata.ext        = cmd_i.ext;
              res_d.status     = ST_OK;
              res_d.slot_index = slot_idx(count_q[IW-1:0]);
              count_d          = count_q + CW'(1);
            end
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          we               = 1'b1;
          waddr            = chk_idx_q;
          res_d.status     = ST_OK;
          res_d.slot_index = slot_idx(chk_idx_q);
          if (cmd_q.op == OP_READ) begin
            res_d.channel = rdata_q.bus;
            res_d.length  = rdata_q.len;
            res_d.remote  = rdata_q.rtr;
            res_d.payload = rdata_q.bytes;
            wdata.full    = 1'b0;
            wdata.bytes   = '0;
          end else begin
            wdata.full  = 1'b1;
            wdata.bus   = cmd_q.bus;
            wdata.len   = cmd_q.len;
            wdata.rtr   = cmd_q.rtr;
            wdata.bytes = cmd_q.data;
          end
        end else if (!scan_end) begin
          rd_en     = 1'b1;
          chk_d     = 1'b1;
          chk_idx_d = scan_q[IW-1:0];
          scan_d    = scan_q + CW'(1);
        end
      end
      S_RESP: begin
        chk_d = 1'b0;
      end
      default: begin
        chk_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      scan_q    <= '0;
      chk_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      chk_q   <= chk_d;
      if (state_q == S_RESP && out_free) begin
        out_vld_q <= 1'b1;
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    res_q     <= res_d;
    chk_idx_q <= chk_idx_d;
    if (state_q == S_RESP && out_free) begin
      out_q <= res_q;
    end
  end

  // slot memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign empty_o = !out_vld_q;
  assign res_o   = out_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(SLOTS))
    else $error("bound slot count exceeds table size");

  a_chk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_q |-> ((CW+1)'(chk_idx_q) < (CW+1)'(count_q)))
    else $error("compare of an unbound slot");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ($past(state_q) == S_IDLE && $past(cmd_take_o) && $past(cmd_i.op) == OP_ASSIGN))
    else $error("slot count changed without an assign request");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && res_q.status == ST_FULL) |-> tab_full)
    else $error("table full reported with free slots");
`endif

endmodule

>>> hw/rtl/can_receive_mailbox_table.sv
// ----------------------------------------------------------------------------
// can_receive_mailbox_table
// Table of CAN receive mailboxes with assign, store and read-by-id requests.
// ----------------------------------------------------------------------------
// Each request gives exactly one result. A frame or read request scans
// the bound slots in order, one slot per cycle out of a single-port slot
// memory. A two-entry request queue and a result register let both sides
// stall on their own; requests are executed one at a time.
module can_receive_mailbox_table #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  req_type_i,
  input  logic                        bus_i,
  input  logic [crmt_pkg::IdW-1:0]    can_id_i,
  input  logic                        id_extended_i,
  input  logic                        remote_in_i,
  input  logic [crmt_pkg::LenW-1:0]   length_in_i,
  input  logic [crmt_pkg::DataW-1:0]  payload_in_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [1:0]                  status_o,
  output logic [crmt_pkg::SlotIdxW-1:0] slot_index_o,
  output logic                        out_channel_o,
  output logic [crmt_pkg::LenW-1:0]   out_length_o,
  output logic                        out_remote_o,
  output logic [crmt_pkg::DataW-1:0]  out_payload_o
);
  import crmt_pkg::*;

  cmd_t cmd;
  logic cmd_vld;
  logic cmd_take;
  res_t res;

  crmt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .req_type_i    (req_type_i),
    .bus_i         (bus_i),
    .can_id_i      (can_id_i),
    .id_extended_i (id_extended_i),
    .remote_in_i   (remote_in_i),
    .length_in_i   (length_in_i),
    .payload_in_i  (payload_in_i),
    .cmd_vld_o     (cmd_vld),
    .cmd_o         (cmd),
    .cmd_take_i    (cmd_take)
  );

  crmt_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_vld_i  (cmd_vld),
    .cmd_i      (cmd),
    .cmd_take_o (cmd_take),
    .empty_o    (empty),
    .pop_i      (pop),
    .res_o      (res)
  );

  assign status_o      = res.status;
  assign slot_index_o  = res.slot_index;
  assign out_channel_o = res.channel;
  assign out_length_o  = res.length;
  assign out_remote_o  = res.remote;
  assign out_payload_o = res.payload;

endmodule

>>> verif/can_receive_mailbox_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_receive_mailbox_table_tb
// Checks the receive mailbox table against an in-bench model of its slots.
// Directed requests cover unbound slots, identifier extremes, duplicate
// bindings, length saturation and unknown requests. Then random requests
// of every type run over a small pool of identifiers, with random stalls on
// both queue sides. Every result is compared field by field, in order.
// ----------------------------------------------------------------------------
module can_receive_mailbox_table_tb;
  import crmt_pkg::*;

  localparam int unsigned MAILBOXES = 16;
  localparam int unsigned POOL_SIZE = 12;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam logic [IdW-1:0] ID_MAX = {IdW{1'b1}};
  localparam logic [DataW-1:0] DATA_ONES = {DataW{1'b1}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [1:0] req_type_i = '0;
  logic bus_i = 1'b0;
  logic [IdW-1:0] can_id_i = '0;
  logic id_extended_i = 1'b0;
  logic remote_in_i = 1'b0;
  logic [LenW-1:0] length_in_i = '0;
  logic [DataW-1:0] payload_in_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [1:0] status_o;
  logic [SlotIdxW-1:0] slot_index_o;
  logic out_channel_o;
  logic [LenW-1:0] out_length_o;
  logic out_remote_o;
  logic [DataW-1:0] out_payload_o;

  cmd_t pending_requests[$];
  res_t expected_results[$];
  cmd_t cur_request;
  ent_t mailbox_slots[MAILBOXES];
  int unsigned bound_count = 0;
  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 64;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  logic [IdW-1:0] pool_id[POOL_SIZE];
  logic pool_ext[POOL_SIZE];

  can_receive_mailbox_table #(
    .SLOTS(MAILBOXES)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .req_type_i    (req_type_i),
    .bus_i         (bus_i),
    .can_id_i      (can_id_i),
    .id_extended_i (id_extended_i),
    .remote_in_i   (remote_in_i),
    .length_in_i   (length_in_i),
    .payload_in_i  (payload_in_i),
    .empty         (empty),
    .pop           (pop),
    .status_o      (status_o),
    .slot_index_o  (slot_index_o),
    .out_channel_o (out_channel_o),
    .out_length_o  (out_length_o),
    .out_remote_o  (out_remote_o),
    .out_payload_o (out_payload_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic res_t mailbox_outcome(input cmd_t c);
    res_t r;
    logic [LenW-1:0] len;
    logic [DataW-1:0] data;
    logic hit;
    r = '0;
    r.status = ST_NONE;
    hit = 1'b0;
    len = c.len;
    if (len > LenW'(MaxLen)) len = LenW'(MaxLen);
    data = c.data;
    for (int b = 0; b < 8; b++) begin
      if (b >= len) data[8*b +: 8] = '0;
    end
    case (c.op)
      OP_ASSIGN: begin
        if (bound_count >= MAILBOXES) begin
          r.status = ST_FULL;
        end else begin
          mailbox_slots[bound_count] = '0;
          mailbox_slots[bound_count].ident = c.id;
          mailbox_slots[bound_count].ext = c.ext;
          r.status = ST_OK;
          r.slot_index = bound_count[SlotIdxW-1:0];
          bound_count++;
        end
      end
      OP_FRAME: begin
        for (int s = 0; s < bound_count; s++) begin
          if (!hit && !mailbox_slots[s].full && mailbox_slots[s].ident == c.id &&
              mailbox_slots[s].ext == c.ext) begin
            hit = 1'b1;
            mailbox_slots[s].full = 1'b1;
            mailbox_slots[s].bus = c.bus;
            mailbox_slots[s].len = len;
            mailbox_slots[s].rtr = c.rtr;
            mailbox_slots[s].bytes = data;
            r.status = ST_OK;
            r.slot_index = s[SlotIdxW-1:0];
          end
        end
      end
      OP_READ: begin
        for (int s = 0; s < bound_count; s++) begin
          if (!hit && mailbox_slots[s].full && mailbox_slots[s].ident == c.id &&
              mailbox_slots[s].ext == c.ext) begin
            hit = 1'b1;
            r.status = ST_OK;
            r.slot_index = s[SlotIdxW-1:0];
            r.channel = mailbox_slots[s].bus;
            r.length = mailbox_slots[s].len;
            r.remote = mailbox_slots[s].rtr;
            r.payload = mailbox_slots[s].bytes;
            mailbox_slots[s].full = 1'b0;
            mailbox_slots[s].bytes = '0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_request(input op_e op, input logic bus, input logic [IdW-1:0] id,
                               input logic ext, input logic rtr, input logic [LenW-1:0] len,
                               input logic [DataW-1:0] data);
    cmd_t c;
    c.op = op;
    c.bus = bus;
    c.id = id;
    c.ext = ext;
    c.rtr = rtr;
    c.len = len;
    c.data = data;
    pending_requests.push_back(c);
  endtask

  task automatic queue_random_requests(input int unsigned count);
    int unsigned kind;
    int unsigned pick;
    op_e op;
    logic [IdW-1:0] id;
    logic ext;
    for (int unsigned n = 0; n < count; n++) begin
      kind = $urandom_range(99);
      pick = $urandom_range(POOL_SIZE - 1);
      id = pool_id[pick];
      ext = pool_ext[pick];
      if (kind < 8) op = OP_ASSIGN;
      else if (kind < 52) op = OP_FRAME;
      else if (kind < 96) op = OP_READ;
      else op = OP_NONE;
      // stray identifiers that should miss every slot
      if (op != OP_ASSIGN && $urandom_range(99) < 20) begin
        id = IdW'($urandom);
        ext = 1'($urandom_range(1));
      end
      queue_request(op, 1'($urandom_range(1)), id, ext, 1'($urandom_range(1)),
                    LenW'($urandom_range(15)), {$urandom, $urandom});
    end
  endtask

  task automatic check_field(input string name, input logic [DataW-1:0] exp_val,
                             input logic [DataW-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) expected_results.push_back(mailbox_outcome(cur_request));
      if (!push || !full) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_request = pending_requests.pop_front();
          push <= 1'b1;
          req_type_i <= cur_request.op;
          bus_i <= cur_request.bus;
          can_id_i <= cur_request.id;
          id_extended_i <= cur_request.ext;
          remote_in_i <= cur_request.rtr;
          length_in_i <= cur_request.len;
          payload_in_i <= cur_request.data;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_res;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: status 0x%0h slot %0d", status_o, slot_index_o);
          mismatches++;
        end else begin
          exp_res = expected_results.pop_front();
          check_field("status", DataW'(exp_res.status), DataW'(status_o));
          check_field("slot_index", DataW'(exp_res.slot_index), DataW'(slot_index_o));
          check_field("out_channel", DataW'(exp_res.channel), DataW'(out_channel_o));
          check_field("out_length", DataW'(exp_res.length), DataW'(out_length_o));
          check_field("out_remote", DataW'(exp_res.remote), DataW'(out_remote_o));
          check_field("out_payload", exp_res.payload, out_payload_o);
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_ext[i] = 1'($urandom_range(1));
      pool_id[i] = pool_ext[i] ? IdW'($urandom) : IdW'($urandom_range(2047));
    end
    // same identifier under both kinds
    pool_id[1] = pool_id[0];
    pool_ext[1] = ~pool_ext[0];

    // unbound slots must not match, even for identifier zero
    queue_request(OP_FRAME, 1'b1, '0, 1'b0, 1'b1, 4'd8, DATA_ONES);
    queue_request(OP_READ, 1'b0, '0, 1'b0, 1'b0, 4'd0, '0);
    queue_request(OP_NONE, 1'b1, ID_MAX, 1'b1, 1'b1, 4'd15, DATA_ONES);
    queue_request(OP_ASSIGN, 1'b0, '0, 1'b0, 1'b0, 4'd0, '0);
    queue_request(OP_ASSIGN, 1'b1, ID_MAX, 1'b1, 1'b1, 4'd15, DATA_ONES);
    queue_request(OP_ASSIGN, 1'b0, ID_MAX, 1'b0, 1'b0, 4'd0, '0);
    queue_request(OP_ASSIGN, 1'b0, '0, 1'b0, 1'b0, 4'd0, '0);
    // long length saturates, zero length clears every byte
    queue_request(OP_FRAME, 1'b1, '0, 1'b0, 1'b1, 4'd15, DATA_ONES);
    queue_request(OP_FRAME, 1'b0, '0, 1'b0, 1'b0, 4'd0, DATA_ONES);
    queue_request(OP_FRAME, 1'b1, '0, 1'b0, 1'b1, 4'd5, DATA_ONES);
    queue_request(OP_FRAME, 1'b1, ID_MAX, 1'b1, 1'b0, 4'd3, 64'h0123_4567_89ab_cdef);
    queue_request(OP_READ, 1'b0, ID_MAX, 1'b0, 1'b0, 4'd0, '0);
    queue_request(OP_READ, 1'b1, '0, 1'b0, 1'b1, 4'd15, DATA_ONES);
    queue_request(OP_READ, 1'b0, '0, 1'b0, 1'b0, 4'd0, '0);
    queue_request(OP_READ, 1'b0, '0, 1'b0, 1'b0, 4'd0, '0);
    queue_request(OP_READ, 1'b0, ID_MAX, 1'b1, 1'b0, 4'd0, '0);
    queue_request(OP_FRAME, 1'b0, ID_MAX, 1'b0, 1'b1, 4'd8, 64'hfedc_ba98_7654_3210);
    queue_request(OP_FRAME, 1'b1, ID_MAX, 1'b0, 1'b0, 4'd7, DATA_ONES);
    queue_request(OP_READ, 1'b1, ID_MAX, 1'b0, 1'b1, 4'd0, '0);
    for (int i = 0; i < 14; i++) begin
      queue_request(OP_ASSIGN, 1'b0, pool_id[i % POOL_SIZE], pool_ext[i % POOL_SIZE],
                    1'b0, 4'd0, '0);
    end
    queue_request(OP_ASSIGN, 1'b1, ID_MAX, 1'b1, 1'b1, 4'd15, DATA_ONES);
    queue_random_requests(600);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0) @(posedge clk_i);
    send_idle_pct = 64;
    recv_idle_pct = 29;
    queue_random_requests(600);
    while (pending_requests.size() != 0) @(posedge clk_i);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_requests(600);
    while (pending_requests.size() != 0 || push || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/crmt_pkg.sv
hw/rtl/crmt_front.sv
hw/rtl/crmt_back.sv
hw/rtl/can_receive_mailbox_table.sv
verif/can_receive_mailbox_table_tb.sv
